/* rtl/core/ssc_pkg.sv */
package ssc_pkg;

	// store geometry
	localparam int MAX_SEGMENTS = 1024;
	localparam int COORD_BITS   = 32;
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int ADDR_W       = $clog2(MAX_SEGMENTS);

	// stream field widths
	localparam int FIELD_W   = 32;
	localparam int OP_W      = 2;
	localparam int IN_DATA_W = 3 * FIELD_W;
	localparam int COUNT_W   = 12;
	localparam int OUT_DATA_W = 16;

	// saturation bounds of the reported count
	localparam int COUNT_MAX = 2047;
	localparam int COUNT_MIN = -2048;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// request from the control to one sorted store
	typedef struct packed {
		logic   go;
		logic   ins;
		coord_t key;
		cnt_t   total;
	} ssc_req_t;

	// status back from one sorted store
	typedef struct packed {
		logic busy;
		cnt_t count;
	} ssc_stat_t;

	// wrap a 32-bit signed field to a coordinate of COORD_BITS bits
	function automatic coord_t to_coord(input logic [FIELD_W-1:0] f);
		logic signed [63:0] ext;
		ext = 64'(signed'(f));
		return ext[COORD_BITS-1:0];
	endfunction

endpackage

/* rtl/core/ssc_store.sv */
module ssc_store (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              strict,
	input  ssc_pkg::ssc_req_t req,
	output ssc_pkg::ssc_stat_t stat
);
	import ssc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STEP  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;

	coord_t mem [MAX_SEGMENTS];

	logic [2:0]        state_q;
	logic              ins_q;
	coord_t            key_q;
	cnt_t              total_q;
	cnt_t              lo_q;
	cnt_t              step_q;
	cnt_t              cand_q;
	cnt_t              ptr_q;
	logic              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;
	coord_t            rdata_q;

	cnt_t              cand;
	logic [ADDR_W-1:0] raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	coord_t            wdata;
	logic              hit;

	assign cand = lo_q + step_q;
	assign hit  = (strict && !ins_q) ? (rdata_q < key_q) : (rdata_q <= key_q);

	// pick the read address for a probe or for the next shift source
	always_comb begin
		raddr = '0;
		if (state_q == S_SHIFT) begin
			raddr = ADDR_W'(ptr_q - 1'b1);
		end else begin
			raddr = ADDR_W'(cand - 1'b1);
		end
	end

	// write either the shifted entry or the new key
	always_comb begin
		we    = pend_q || (state_q == S_PUT);
		waddr = pend_q ? pend_addr_q : lo_q[ADDR_W-1:0];
		wdata = pend_q ? rdata_q : key_q;
	end

	// memory with one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// search and insertion sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					if (req.go) begin
						state_q <= S_STEP;
						ins_q   <= req.ins;
						key_q   <= req.key;
						total_q <= req.total;
						lo_q    <= '0;
						step_q  <= {1'b1, {(CNT_W-1){1'b0}}};
					end
				end
				S_STEP: begin
					if (step_q == '0) begin
						if (ins_q) begin
							ptr_q   <= total_q;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						step_q <= step_q >> 1;
						if (cand <= total_q) begin
							cand_q  <= cand;
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (hit) begin
						lo_q <= cand_q;
					end
					state_q <= S_STEP;
				end
				S_SHIFT: begin
					if (ptr_q > lo_q) begin
						pend_q      <= 1'b1;
						pend_addr_q <= ptr_q[ADDR_W-1:0];
						ptr_q       <= ptr_q - 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.busy  = (state_q != S_IDLE);
	assign stat.count = lo_q;

endmodule

/* rtl/core/segment_stabbing_counter.sv */
// Counts how many stored closed segments contain a query point. Each request
// carries an operation in s_tuser: clear empties the set; load inserts the
// start and the end into two sorted memories (a load beyond MAX_SEGMENTS is
// dropped and sets the sticky drop flag); query returns the number of starts
// at or below the point minus the number of ends below it, saturated to 12
// bits, with the drop flag in m_tuser. Unused operation codes are ignored. A
// query does a binary search in both memories side by side. A load does the
// same search and then moves every entry above the insertion point up by one,
// one entry a cycle through the single write port of each memory. One request
// is worked at a time; the next is accepted while a finished result still
// waits in the output register.
module segment_stabbing_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// seg_start [31:0], seg_end [63:32], query_point [95:64]
	input  logic [ssc_pkg::IN_DATA_W-1:0]    s_tdata,
	// operation [1:0]
	input  logic [ssc_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cover_count [11:0], zero fill [15:12]
	output logic [ssc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// segments_dropped [0]
	output logic                             m_tuser
);
	import ssc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic                      state_q;
	logic                      qry_q;
	cnt_t                      total_q;
	logic                      drop_q;
	logic                      out_valid_q;
	logic signed [COUNT_W-1:0] out_count_q;
	logic                      out_drop_q;

	ssc_req_t  st_req, en_req;
	ssc_stat_t st_stat, en_stat;

	logic                      accept;
	logic                      full;
	logic                      slot_free;
	logic                      res_load;
	logic signed [CNT_W:0]     diff;
	logic signed [31:0]        diff_ext;
	logic signed [COUNT_W-1:0] sat_count;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign full      = (total_q == CNT_W'(MAX_SEGMENTS));
	assign slot_free = !out_valid_q || m_tready;

	// a finished query moves into the output register this cycle
	assign res_load  = (state_q == ST_BUSY) && qry_q && !st_stat.busy && !en_stat.busy
	                   && slot_free;

	// issue store requests on an accepted query or on an accepted load that fits
	always_comb begin
		st_req.go    = accept && ((s_tuser == OP_QUERY) || ((s_tuser == OP_LOAD) && !full));
		st_req.ins   = (s_tuser == OP_LOAD);
		st_req.key   = to_coord(s_tdata[FIELD_W-1:0]);
		st_req.total = total_q;
		en_req.go    = st_req.go;
		en_req.ins   = st_req.ins;
		en_req.key   = (s_tuser == OP_LOAD) ? to_coord(s_tdata[2*FIELD_W-1:FIELD_W])
		                                    : to_coord(s_tdata[3*FIELD_W-1:2*FIELD_W]);
		en_req.total = total_q;
		if (s_tuser == OP_QUERY) begin
			st_req.key = to_coord(s_tdata[3*FIELD_W-1:2*FIELD_W]);
		end
	end

	ssc_store u_starts (
		.clk    (clk),
		.arst_n (arst_n),
		.strict (1'b0),
		.req    (st_req),
		.stat   (st_stat)
	);

	ssc_store u_ends (
		.clk    (clk),
		.arst_n (arst_n),
		.strict (1'b1),
		.req    (en_req),
		.stat   (en_stat)
	);

	// saturate the count difference to the result width
	always_comb begin
		diff     = signed'({1'b0, st_stat.count}) - signed'({1'b0, en_stat.count});
		diff_ext = 32'(diff);
		if (diff_ext > COUNT_MAX) begin
			sat_count = COUNT_W'(COUNT_MAX);
		end else if (diff_ext < COUNT_MIN) begin
			sat_count = COUNT_W'(COUNT_MIN);
		end else begin
			sat_count = diff_ext[COUNT_W-1:0];
		end
	end

	// sequence requests and hold the set size and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qry_q       <= 1'b0;
			total_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !res_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							OP_CLEAR: begin
								total_q <= '0;
								drop_q  <= 1'b0;
							end
							OP_LOAD: begin
								if (full) begin
									drop_q <= 1'b1;
								end else begin
									total_q <= total_q + 1'b1;
									qry_q   <= 1'b0;
									state_q <= ST_BUSY;
								end
							end
							OP_QUERY: begin
								qry_q   <= 1'b1;
								state_q <= ST_BUSY;
							end
							default: begin
							end
						endcase
					end
				end
				ST_BUSY: begin
					if (!st_stat.busy && !en_stat.busy) begin
						if (!qry_q) begin
							state_q <= ST_IDLE;
						end else if (slot_free) begin
							out_valid_q <= 1'b1;
							out_count_q <= sat_count;
							out_drop_q  <= drop_q;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-COUNT_W){1'b0}}, out_count_q};
	assign m_tuser  = out_drop_q;

	// set size never passes the store depth
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment total exceeds store depth");

	// a new request is taken only with both stores at rest
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!st_stat.busy && !en_stat.busy))
		else $error("request accepted while a store is busy");

	// a clear empties the set and drops the flag
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == OP_CLEAR)) |=> (total_q == '0) && !drop_q)
		else $error("clear did not empty the set");

endmodule

/* bench/tb_segment_stabbing_counter.sv */
module tb_segment_stabbing_counter;
	import ssc_pkg::*;

	// the one operation code the block ignores
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 1100;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               dropped;
	} cover_result_t;

	// tracks the segment set and the query answers still owed by the block
	class cover_scoreboard;
		coord_t        starts[$];
		coord_t        ends[$];
		bit            dropped_flag;
		cover_result_t awaited[$];
		int            errors;

		task report(string what, int got, int wanted);
			$display("mismatch on %s: got %0d, expected %0d", what, got, wanted);
			errors++;
		endtask

		// apply one accepted request to the set; queue the answer for a query
		function void note_request(logic [OP_W-1:0] op, coord_t s, coord_t e, coord_t p);
			int            at_or_below;
			int            below;
			int            c;
			cover_result_t r;
			at_or_below = 0;
			below = 0;
			case (op)
				OP_CLEAR: begin
					starts.delete();
					ends.delete();
					dropped_flag = 1'b0;
				end
				OP_LOAD: begin
					if (starts.size() >= MAX_SEGMENTS) begin
						dropped_flag = 1'b1;
					end else begin
						starts.push_back(s);
						ends.push_back(e);
					end
				end
				OP_QUERY: begin
					foreach (starts[i]) if (starts[i] <= p) at_or_below++;
					foreach (ends[i]) if (ends[i] < p) below++;
					c = at_or_below - below;
					if (c > COUNT_MAX) c = COUNT_MAX;
					if (c < COUNT_MIN) c = COUNT_MIN;
					r.count = COUNT_W'(c);
					r.dropped = dropped_flag;
					awaited.push_back(r);
				end
				default: ;
			endcase
		endfunction

		// compare one accepted result with the oldest owed answer
		task check_result(logic [OUT_DATA_W-1:0] data, logic flag);
			cover_result_t want;
			if (awaited.size() == 0) begin
				report("result with no query waiting", signed'(data[COUNT_W-1:0]), 0);
				return;
			end
			want = awaited.pop_front();
			if (data[COUNT_W-1:0] !== want.count)
				report("cover_count", signed'(data[COUNT_W-1:0]), signed'(want.count));
			if (data[OUT_DATA_W-1:COUNT_W] !== '0)
				report("zero fill", data[OUT_DATA_W-1:COUNT_W], 0);
			if (flag !== want.dropped)
				report("segments_dropped", flag, want.dropped);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	cover_scoreboard sb = new();
	int  tx_idle_pct;
	int  rx_idle_pct;
	int  requests_sent;
	int  cycles;
	bit  rx_hold_req;
	bit  rx_hold_seen;
	int  rx_hold_left;

	segment_stabbing_counter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run as failed once it reaches the cycle limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// result side: check on handshake, then stall at random or hold off on demand
	initial begin
		m_tready = 1'b0;
		rx_hold_seen = 1'b0;
		rx_hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (rx_hold_req != rx_hold_seen) begin
				rx_hold_seen = rx_hold_req;
				rx_hold_left = RX_HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offer one request, wait for it to be taken, then maybe idle a while
	task automatic send_request(logic [OP_W-1:0] op, coord_t s, coord_t e, coord_t p);
		int gap;
		gap = 0;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {p, e, s};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, s, e, p);
		if (op != OP_UNUSED) requests_sent++;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every owed answer has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	function automatic coord_t pick_extreme();
		case ($urandom_range(6))
			0: return 32'h8000_0000;
			1: return 32'h8000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return 32'h0000_0001;
			5: return 32'h7FFF_FFFE;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	// mostly a narrow window so that queries land on stored endpoints
	function automatic coord_t pick_near(coord_t base);
		int r;
		r = $urandom_range(99);
		if (r < 75) return base + coord_t'($urandom_range(63));
		if (r < 90) return $urandom;
		return pick_extreme();
	endfunction

	task automatic run_directed();
		send_request(OP_QUERY, $urandom, $urandom, 0);
		send_request(OP_UNUSED, $urandom, $urandom, $urandom);
		send_request(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, $urandom);
		send_request(OP_LOAD, 5, 5, $urandom);
		// reversed segment: start above end
		send_request(OP_LOAD, 10, 0, $urandom);
		send_request(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom);
		send_request(OP_LOAD, 32'h8000_0000, 32'h8000_0000, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 32'h8000_0000);
		send_request(OP_QUERY, $urandom, $urandom, 32'h7FFF_FFFF);
		send_request(OP_QUERY, $urandom, $urandom, 5);
		send_request(OP_QUERY, $urandom, $urandom, 4);
		send_request(OP_QUERY, $urandom, $urandom, 6);
		send_request(OP_QUERY, $urandom, $urandom, 0);
		send_request(OP_QUERY, $urandom, $urandom, 10);
		send_request(OP_QUERY, $urandom, $urandom, -1);
		send_request(OP_UNUSED, $urandom, $urandom, $urandom);
		send_request(OP_CLEAR, $urandom, $urandom, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 0);
		// duplicate endpoints
		send_request(OP_LOAD, 0, 0, $urandom);
		send_request(OP_LOAD, 0, 0, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 0);
		send_request(OP_QUERY, $urandom, $urandom, 1);
		send_request(OP_CLEAR, $urandom, $urandom, $urandom);
		// only a reversed segment: negative count
		send_request(OP_LOAD, 1, -1, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 0);
	endtask

	// hold the result side off while queries keep coming, so the input stalls
	task automatic run_backpressure();
		coord_t base;
		base = $urandom;
		send_request(OP_CLEAR, $urandom, $urandom, $urandom);
		repeat (6) send_request(OP_LOAD, pick_near(base), pick_near(base), $urandom);
		rx_hold_req <= ~rx_hold_req;
		repeat (30) send_request(OP_QUERY, $urandom, $urandom, pick_near(base));
	endtask

	// mostly well-formed runs of loads and queries over a small set, plus noise
	task automatic run_random(int upto);
		coord_t base;
		coord_t a;
		coord_t b;
		coord_t t;
		while (requests_sent < upto) begin
			if ($urandom_range(99) < 80) begin
				base = ($urandom_range(99) < 80) ? coord_t'($urandom) :
					pick_extreme() - coord_t'($urandom_range(63));
				if (sb.starts.size() > 150 || $urandom_range(99) < 70)
					send_request(OP_CLEAR, $urandom, $urandom, $urandom);
				repeat ($urandom_range(2, 30)) begin
					if ($urandom_range(99) < 55) begin
						a = pick_near(base);
						b = pick_near(base);
						if (a > b && $urandom_range(99) < 85) begin
							t = a;
							a = b;
							b = t;
						end
						send_request(OP_LOAD, a, b, $urandom);
					end else begin
						send_request(OP_QUERY, $urandom, $urandom, pick_near(base));
					end
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(OP_W'($urandom_range(3)), $urandom, $urandom, $urandom);
			end
		end
	endtask

	// fill the store, mostly in rising order, then overflow it
	task automatic run_full_store();
		coord_t s;
		coord_t e;
		int     i;
		send_request(OP_CLEAR, $urandom, $urandom, $urandom);
		for (i = 0; i < MAX_SEGMENTS + 3; i++) begin
			if ($urandom_range(15) == 0) begin
				s = $urandom;
				e = $urandom;
			end else begin
				s = 32'hC000_0000 + i * 8 + $urandom_range(7);
				e = 32'h0010_0000 + i * 8 + $urandom_range(7);
			end
			send_request(OP_LOAD, s, e, $urandom);
			if (i % 256 == 255 || i >= MAX_SEGMENTS)
				send_request(OP_QUERY, $urandom, $urandom, 0);
		end
		send_request(OP_QUERY, $urandom, $urandom, 32'h8000_0000);
		send_request(OP_QUERY, $urandom, $urandom, 32'h7FFF_FFFF);
		send_request(OP_UNUSED, $urandom, $urandom, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 32'h0010_0000);
		send_request(OP_CLEAR, $urandom, $urandom, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 0);
		send_request(OP_LOAD, -3, 3, $urandom);
		send_request(OP_QUERY, $urandom, $urandom, 3);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		rx_hold_req = 1'b0;
		requests_sent = 0;
		tx_idle_pct = 28;
		rx_idle_pct = 51;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_backpressure();
		wait_for_results();
		run_random(150);
		wait_for_results();

		tx_idle_pct = 51;
		rx_idle_pct = 28;
		run_random(225);
		wait_for_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(300);
		run_full_store();
		wait_for_results();

		// let any late or spurious result show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/core/ssc_pkg.sv
rtl/core/ssc_store.sv
rtl/core/segment_stabbing_counter.sv
bench/tb_segment_stabbing_counter.sv
